// ===== rtl/pob_pkg.sv =====
package pob_pkg;

    localparam int TIME_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int LIMIT_W  = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    // input opcodes
    localparam logic OP_PKT  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT     = 2'd2;

    // result kinds
    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_OAM  = 2'd1,
        KIND_DROP = 2'd2
    } kind_t;

    // per-cell operation, broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] now;
    } cell_ctl_t;

    // entry payload besides the sequence number
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   deadline;
    } entry_t;

    // earliest-deadline candidate moving along the chain
    typedef struct packed {
        logic   found;
        entry_t ent;
    } best_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_TCHECK,
        ST_TSEARCH,
        ST_FLUSH
    } state_t;

endpackage

// ===== rtl/packet_ordering_buffer.sv =====
// flow: a request is accepted only in the idle state; its results pass through the pending
// register into the output register, the drain state releases in-order heads, flush marks last
// a tick with entries runs an expiry check and may run an earliest-deadline search of the chain
// throughput: one request at a time; the input stalls outside the idle state
// reset: asynchronous active low, clears fill count, time, counters and
// handshake state; the accept-any flag is set and queue_limit is 32
module packet_ordering_buffer #(
    parameter int DEPTH    = 32,
    parameter int SEQ_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [SEQ_BITS-1:0]   seq_num,
    input  logic [15:0]           pkt_handle,
    input  logic                  is_oam,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            kind,
    output logic [15:0]           out_handle,
    output logic [SEQ_BITS-1:0]   out_seq,
    output logic                  by_timeout,
    output logic                  last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LIM_W = (CNT_W > pob_pkg::LIMIT_W) ? CNT_W : pob_pkg::LIMIT_W;
    localparam int TW    = pob_pkg::TIME_W;

    // configuration
    logic [TW-1:0]                max_delay_reg;
    logic [TW-1:0]                idle_limit_reg;
    logic [pob_pkg::LIMIT_W-1:0]  queue_limit_reg;

    // control state
    pob_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [SEQ_BITS-1:0]  last_sent_reg, last_sent_next;
    logic                 any_seq_reg, any_seq_next;
    logic [TW-1:0]        now_reg, now_next;
    logic [TW-1:0]        idle_reg, idle_next;
    logic                 from_tick_reg, from_tick_next;
    logic [CNT_W-1:0]     srch_cnt_reg, srch_cnt_next;

    // pending result and output register
    logic                 pend_v_reg, pend_v_next;
    pob_pkg::kind_t       pend_kind_reg, pend_kind_next;
    logic [15:0]          pend_handle_reg, pend_handle_next;
    logic [SEQ_BITS-1:0]  pend_seq_reg, pend_seq_next;
    logic                 pend_to_reg, pend_to_next;
    logic                 out_valid_reg, out_valid_next;
    pob_pkg::kind_t       out_kind_reg, out_kind_next;
    logic [15:0]          out_handle_reg, out_handle_next;
    logic [SEQ_BITS-1:0]  out_seq_reg, out_seq_next;
    logic                 out_to_reg, out_to_next;
    logic                 out_last_reg, out_last_next;

    // chain wiring
    pob_pkg::cell_ctl_t   ctl;
    logic [IDX_W-1:0]     rel_idx;
    pob_pkg::entry_t      new_ent;
    logic [DEPTH:0]       less_chain;
    logic [DEPTH-1:0]     expired_v;
    logic [SEQ_BITS-1:0]  c_seq [DEPTH];
    pob_pkg::entry_t      c_ent [DEPTH];
    pob_pkg::best_t       c_best [DEPTH+1];
    logic [SEQ_BITS-1:0]  c_bseq [DEPTH+1];
    logic [IDX_W-1:0]     c_bidx [DEPTH+1];

    // helpers
    logic                 in_acc;
    logic                 out_free;
    logic [TW:0]          dl_sum;
    logic [SEQ_BITS:0]    want;
    logic [SEQ_BITS:0]    head_seq_ext;
    logic                 head_ok;
    logic [LIM_W-1:0]     limit;
    logic [TW-1:0]        idle_inc;
    logic                 gen;
    pob_pkg::kind_t       gen_kind;
    logic [15:0]          gen_handle;
    logic [SEQ_BITS-1:0]  gen_seq;
    logic                 gen_to;
    logic                 flush_out;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != pob_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign dl_sum  = {1'b0, now_reg} + {1'b0, max_delay_reg};
    assign new_ent = '{handle: pkt_handle,
                       deadline: dl_sum[TW] ? pob_pkg::TIME_MAX : dl_sum[TW-1:0]};

    assign want         = {1'b0, last_sent_reg} + (SEQ_BITS+1)'(1);
    assign head_seq_ext = {1'b0, c_seq[0]};
    assign head_ok      = (fill_reg != '0) && (head_seq_ext <= want);
    assign limit        = (LIM_W'(queue_limit_reg) < LIM_W'(DEPTH))
                          ? LIM_W'(queue_limit_reg) : LIM_W'(DEPTH);
    assign idle_inc     = (idle_reg != pob_pkg::TIME_MAX) ? idle_reg + TW'(1) : idle_reg;

    // cell chain
    assign less_chain[0] = 1'b1;
    assign c_best[0]     = '0;
    assign c_bseq[0]     = '0;
    assign c_bidx[0]     = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            pob_cell #(
                .DEPTH    (DEPTH),
                .SEQ_BITS (SEQ_BITS),
                .IDX      (gi)
            ) u_cell (
                .clk          (clk),
                .ctl          (ctl),
                .fill         (fill_reg),
                .rel_idx      (rel_idx),
                .new_seq      (seq_num),
                .new_ent      (new_ent),
                .left_less    (less_chain[gi]),
                .left_seq     (c_seq[(gi > 0) ? gi-1 : 0]),
                .left_ent     (c_ent[(gi > 0) ? gi-1 : 0]),
                .right_seq    (c_seq[(gi < DEPTH-1) ? gi+1 : gi]),
                .right_ent    (c_ent[(gi < DEPTH-1) ? gi+1 : gi]),
                .best_in      (c_best[gi]),
                .best_seq_in  (c_bseq[gi]),
                .best_idx_in  (c_bidx[gi]),
                .less         (less_chain[gi+1]),
                .expired      (expired_v[gi]),
                .seq          (c_seq[gi]),
                .ent          (c_ent[gi]),
                .best_out     (c_best[gi+1]),
                .best_seq_out (c_bseq[gi+1]),
                .best_idx_out (c_bidx[gi+1])
            );
        end
    endgenerate

    // sequencer: next state, cell operation and result generation
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        last_sent_next = last_sent_reg;
        any_seq_next   = any_seq_reg;
        now_next       = now_reg;
        idle_next      = idle_reg;
        from_tick_next = from_tick_reg;
        srch_cnt_next  = srch_cnt_reg;
        ctl.op         = pob_pkg::CELL_HOLD;
        ctl.now        = now_reg;
        rel_idx        = '0;
        gen            = 1'b0;
        gen_kind       = pob_pkg::KIND_FWD;
        gen_handle     = pkt_handle;
        gen_seq        = seq_num;
        gen_to         = 1'b0;
        flush_out      = 1'b0;

        unique case (state_reg)
            pob_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (opcode == pob_pkg::OP_PKT)
                    begin
                        from_tick_next = 1'b0;
                        if (is_oam)
                        begin
                            gen        = 1'b1;
                            gen_kind   = pob_pkg::KIND_OAM;
                            state_next = pob_pkg::ST_FLUSH;
                        end
                        else if (LIM_W'(fill_reg) >= limit)
                        begin
                            gen        = 1'b1;
                            gen_kind   = pob_pkg::KIND_DROP;
                            state_next = pob_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            ctl.op    = pob_pkg::CELL_INSERT;
                            fill_next = fill_reg + CNT_W'(1);
                            idle_next = '0;
                            if (({1'b0, seq_num} <= want) || any_seq_reg)
                            begin
                                state_next = pob_pkg::ST_DRAIN;
                            end
                            else
                            begin
                                state_next = pob_pkg::ST_FLUSH;
                            end
                        end
                    end
                    else
                    begin
                        from_tick_next = 1'b1;
                        if (now_reg != pob_pkg::TIME_MAX)
                        begin
                            now_next = now_reg + TW'(1);
                        end
                        if (fill_reg == '0)
                        begin
                            idle_next = idle_inc;
                            if (idle_inc >= idle_limit_reg)
                            begin
                                any_seq_next = 1'b1;
                                idle_next    = '0;
                            end
                        end
                        else
                        begin
                            idle_next  = '0;
                            state_next = pob_pkg::ST_TCHECK;
                        end
                    end
                end
            end

            pob_pkg::ST_DRAIN:
            begin
                if (head_ok)
                begin
                    if (!pend_v_reg || out_free)
                    begin
                        ctl.op     = pob_pkg::CELL_REMOVE;
                        fill_next  = fill_reg - CNT_W'(1);
                        gen        = 1'b1;
                        gen_kind   = pob_pkg::KIND_FWD;
                        gen_handle = c_ent[0].handle;
                        gen_seq    = c_seq[0];
                        if (head_seq_ext == want)
                        begin
                            any_seq_next = 1'b0;
                        end
                        if (c_seq[0] > last_sent_reg)
                        begin
                            last_sent_next = c_seq[0];
                        end
                    end
                end
                else if (from_tick_reg)
                begin
                    state_next = pob_pkg::ST_TCHECK;
                end
                else
                begin
                    state_next = pob_pkg::ST_FLUSH;
                end
            end

            pob_pkg::ST_TCHECK:
            begin
                if ((fill_reg == '0) || (expired_v == '0))
                begin
                    state_next = pob_pkg::ST_FLUSH;
                end
                else if (any_seq_reg)
                begin
                    if (!pend_v_reg || out_free)
                    begin
                        ctl.op        = pob_pkg::CELL_REMOVE;
                        fill_next     = fill_reg - CNT_W'(1);
                        any_seq_next  = 1'b0;
                        gen           = 1'b1;
                        gen_handle    = c_ent[0].handle;
                        gen_seq       = c_seq[0];
                        gen_to        = 1'b1;
                        if (c_seq[0] > last_sent_reg)
                        begin
                            last_sent_next = c_seq[0];
                        end
                        state_next    = pob_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    srch_cnt_next = '0;
                    state_next    = pob_pkg::ST_TSEARCH;
                end
            end

            pob_pkg::ST_TSEARCH:
            begin
                if (srch_cnt_reg != CNT_W'(DEPTH))
                begin
                    srch_cnt_next = srch_cnt_reg + CNT_W'(1);
                end
                else if (!pend_v_reg || out_free)
                begin
                    ctl.op        = pob_pkg::CELL_REMOVE;
                    rel_idx       = c_bidx[DEPTH];
                    fill_next     = fill_reg - CNT_W'(1);
                    any_seq_next  = 1'b0;
                    gen           = 1'b1;
                    gen_handle    = c_best[DEPTH].ent.handle;
                    gen_seq       = c_bseq[DEPTH];
                    gen_to        = 1'b1;
                    if (c_bseq[DEPTH] > last_sent_reg)
                    begin
                        last_sent_next = c_bseq[DEPTH];
                    end
                    state_next    = pob_pkg::ST_DRAIN;
                end
            end

            pob_pkg::ST_FLUSH:
            begin
                if (!pend_v_reg)
                begin
                    state_next = pob_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    flush_out  = 1'b1;
                    state_next = pob_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = pob_pkg::ST_IDLE;
            end
        endcase
    end

    // result holding: a new result pushes the pending one out, flush marks last
    always_comb
    begin
        pend_v_next      = pend_v_reg;
        pend_kind_next   = pend_kind_reg;
        pend_handle_next = pend_handle_reg;
        pend_seq_next    = pend_seq_reg;
        pend_to_next     = pend_to_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_kind_next    = out_kind_reg;
        out_handle_next  = out_handle_reg;
        out_seq_next     = out_seq_reg;
        out_to_next      = out_to_reg;
        out_last_next    = out_last_reg;
        if ((gen && pend_v_reg) || flush_out)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_handle_next = pend_handle_reg;
            out_seq_next    = pend_seq_reg;
            out_to_next     = pend_to_reg;
            out_last_next   = flush_out;
        end
        if (gen)
        begin
            pend_v_next      = 1'b1;
            pend_kind_next   = gen_kind;
            pend_handle_next = gen_handle;
            pend_seq_next    = gen_seq;
            pend_to_next     = gen_to;
        end
        else if (flush_out)
        begin
            pend_v_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= pob_pkg::ST_IDLE;
            fill_reg          <= '0;
            last_sent_reg     <= '0;
            any_seq_reg       <= 1'b1;
            now_reg           <= '0;
            idle_reg          <= '0;
            from_tick_reg     <= 1'b0;
            srch_cnt_reg      <= '0;
            pend_v_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
            max_delay_reg     <= '0;
            idle_limit_reg    <= '0;
            queue_limit_reg   <= pob_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            last_sent_reg <= last_sent_next;
            any_seq_reg   <= any_seq_next;
            now_reg       <= now_next;
            idle_reg      <= idle_next;
            from_tick_reg <= from_tick_next;
            srch_cnt_reg  <= srch_cnt_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pob_pkg::CFG_MAX_DELAY:  max_delay_reg <= cfg_data;
                    pob_pkg::CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data;
                    pob_pkg::CFG_QLIMIT:
                        queue_limit_reg <= cfg_data[pob_pkg::LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pend_kind_reg   <= pend_kind_next;
        pend_handle_reg <= pend_handle_next;
        pend_seq_reg    <= pend_seq_next;
        pend_to_reg     <= pend_to_next;
        out_kind_reg    <= out_kind_next;
        out_handle_reg  <= out_handle_next;
        out_seq_reg     <= out_seq_next;
        out_to_reg      <= out_to_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_kind_reg;
    assign out_handle = out_handle_reg;
    assign out_seq    = out_seq_reg;
    assign by_timeout = out_to_reg;
    assign last       = out_last_reg;

endmodule

// ===== rtl/pob_cell.sv =====
module pob_cell #(
    parameter int DEPTH    = 32,
    parameter int SEQ_BITS = 16,
    parameter int IDX      = 0
) (
    input  logic                         clk,
    input  pob_pkg::cell_ctl_t           ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   fill,
    input  logic [$clog2(DEPTH)-1:0]     rel_idx,
    input  logic [SEQ_BITS-1:0]          new_seq,
    input  pob_pkg::entry_t              new_ent,
    input  logic                         left_less,
    input  logic [SEQ_BITS-1:0]          left_seq,
    input  pob_pkg::entry_t              left_ent,
    input  logic [SEQ_BITS-1:0]          right_seq,
    input  pob_pkg::entry_t              right_ent,
    input  pob_pkg::best_t               best_in,
    input  logic [SEQ_BITS-1:0]          best_seq_in,
    input  logic [$clog2(DEPTH)-1:0]     best_idx_in,
    output logic                         less,
    output logic                         expired,
    output logic [SEQ_BITS-1:0]          seq,
    output pob_pkg::entry_t              ent,
    output pob_pkg::best_t               best_out,
    output logic [SEQ_BITS-1:0]          best_seq_out,
    output logic [$clog2(DEPTH)-1:0]     best_idx_out
);

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [SEQ_BITS-1:0]  seq_reg, seq_next;
    pob_pkg::entry_t      ent_reg, ent_next;
    pob_pkg::best_t       best_reg, best_next;
    logic [SEQ_BITS-1:0]  best_seq_reg, best_seq_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic                 valid;

    assign valid   = fill > CNT_W'(IDX);
    assign less    = valid && (seq_reg < new_seq);
    assign expired = valid && (ent_reg.deadline <= ctl.now);

    // insert shifts right of the slot, remove shifts left onto the slot
    always_comb
    begin
        seq_next = seq_reg;
        ent_next = ent_reg;
        unique case (ctl.op)
            pob_pkg::CELL_INSERT:
            begin
                if (!less)
                begin
                    if (left_less)
                    begin
                        seq_next = new_seq;
                        ent_next = new_ent;
                    end
                    else
                    begin
                        seq_next = left_seq;
                        ent_next = left_ent;
                    end
                end
            end
            pob_pkg::CELL_REMOVE:
            begin
                if (IDX_W'(IDX) >= rel_idx)
                begin
                    seq_next = right_seq;
                    ent_next = right_ent;
                end
            end
            default:
            begin
            end
        endcase
    end

    // earliest deadline wave, strict compare keeps the lower position on ties
    always_comb
    begin
        best_next     = best_in;
        best_seq_next = best_seq_in;
        best_idx_next = best_idx_in;
        if (valid && (!best_in.found || (ent_reg.deadline < best_in.ent.deadline)))
        begin
            best_next.found = 1'b1;
            best_next.ent   = ent_reg;
            best_seq_next   = seq_reg;
            best_idx_next   = IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        ent_reg      <= ent_next;
        best_reg     <= best_next;
        best_seq_reg <= best_seq_next;
        best_idx_reg <= best_idx_next;
    end

    assign seq          = seq_reg;
    assign ent          = ent_reg;
    assign best_out     = best_reg;
    assign best_seq_out = best_seq_reg;
    assign best_idx_out = best_idx_reg;

endmodule

// ===== dv/packet_ordering_buffer_check.sv =====
`timescale 1ns / 1ps

module packet_ordering_buffer_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] seq_num,
    input  logic [15:0] pkt_handle,
    input  logic        is_oam,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] out_handle,
    input  logic [15:0] out_seq,
    input  logic        by_timeout,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int SLOTS = 32;

    typedef struct {
        pob_pkg::kind_t kind;
        logic [15:0]    handle;
        logic [15:0]    seq;
        logic           to;
        logic           last;
    } release_t;

    release_t awaited[$];

    // configuration copy
    logic [31:0] delay_cfg;
    logic [31:0] idle_cfg;
    logic [5:0]  limit_cfg;

    // buffer copy, sorted by sequence
    logic [15:0] ord_seq[SLOTS];
    logic [15:0] ord_handle[SLOTS];
    logic [31:0] ord_deadline[SLOTS];
    int          held;
    logic [16:0] sent_seq;
    logic        any_seq;
    logic [31:0] clock_now;
    logic [31:0] idle_run;

    initial
    begin
        errors = 0;
    end

    assign pending = awaited.size();

    task automatic report_err(input string msg);
        $display("packet_ordering_buffer_check: %0t: %s", $time, msg);
        errors++;
    endtask

    task automatic push_release(input pob_pkg::kind_t k, input logic [15:0] h,
                                input logic [15:0] s, input logic to);
        release_t r;
        r.kind = k;
        r.handle = h;
        r.seq = s;
        r.to = to;
        r.last = 1'b0;
        awaited.push_back(r);
    endtask

    task automatic release_slot(input int idx, input logic to);
        if ({1'b0, ord_seq[idx]} > sent_seq)
            sent_seq = {1'b0, ord_seq[idx]};
        push_release(pob_pkg::KIND_FWD, ord_handle[idx], ord_seq[idx], to);
        for (int i = idx; i + 1 < held; i++)
        begin
            ord_seq[i] = ord_seq[i + 1];
            ord_handle[i] = ord_handle[i + 1];
            ord_deadline[i] = ord_deadline[i + 1];
        end
        held--;
    endtask

    // release the head while it is in order
    task automatic drain_in_order();
        logic [16:0] want;
        while (held > 0)
        begin
            want = sent_seq + 17'd1;
            if ({1'b0, ord_seq[0]} == want)
            begin
                any_seq = 1'b0;
                release_slot(0, 1'b0);
            end
            else if ({1'b0, ord_seq[0]} < want)
                release_slot(0, 1'b0);
            else
                break;
        end
    endtask

    task automatic predict_request(input logic op, input logic [15:0] s,
                                   input logic [15:0] h, input logic oam);
        int          pos;
        int          lim;
        int          e;
        int          before_n;
        logic [32:0] sum;
        release_t    r;
        before_n = awaited.size();
        if (op == pob_pkg::OP_PKT)
        begin
            lim = (limit_cfg < SLOTS) ? int'(limit_cfg) : SLOTS;
            if (oam)
                push_release(pob_pkg::KIND_OAM, h, s, 1'b0);
            else if (held >= lim)
                push_release(pob_pkg::KIND_DROP, h, s, 1'b0);
            else
            begin
                pos = 0;
                while (pos < held && ord_seq[pos] < s)
                    pos++;
                for (int i = held; i > pos; i--)
                begin
                    ord_seq[i] = ord_seq[i - 1];
                    ord_handle[i] = ord_handle[i - 1];
                    ord_deadline[i] = ord_deadline[i - 1];
                end
                sum = {1'b0, clock_now} + {1'b0, delay_cfg};
                ord_seq[pos] = s;
                ord_handle[pos] = h;
                ord_deadline[pos] = sum[32] ? pob_pkg::TIME_MAX : sum[31:0];
                held++;
                idle_run = '0;
                if ({1'b0, s} <= sent_seq + 17'd1 || any_seq)
                    drain_in_order();
            end
        end
        else
        begin
            if (clock_now != pob_pkg::TIME_MAX)
                clock_now++;
            if (held == 0)
            begin
                if (idle_run != pob_pkg::TIME_MAX)
                    idle_run++;
                if (idle_run >= idle_cfg)
                begin
                    any_seq = 1'b1;
                    idle_run = '0;
                end
            end
            else
            begin
                idle_run = '0;
                // forced release of expired entries
                while (held > 0)
                begin
                    e = 0;
                    for (int i = 1; i < held; i++)
                        if (ord_deadline[i] < ord_deadline[e])
                            e = i;
                    if (ord_deadline[e] > clock_now)
                        break;
                    if (any_seq)
                        e = 0;
                    any_seq = 1'b0;
                    release_slot(e, 1'b1);
                    drain_in_order();
                end
            end
        end
        if (awaited.size() > before_n)
        begin
            r = awaited[$];
            r.last = 1'b1;
            awaited[$] = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg = '0;
            idle_cfg = '0;
            limit_cfg = pob_pkg::LIMIT_RESET;
            held = 0;
            sent_seq = '0;
            any_seq = 1'b1;
            clock_now = '0;
            idle_run = '0;
            awaited.delete();
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pob_pkg::CFG_MAX_DELAY:  delay_cfg = cfg_data;
                    pob_pkg::CFG_IDLE_LIMIT: idle_cfg = cfg_data;
                    pob_pkg::CFG_QLIMIT:     limit_cfg = cfg_data[5:0];
                    default: ;
                endcase
            end
            // accepted request
            if (in_valid && !in_stall)
                predict_request(opcode, seq_num, pkt_handle, is_oam);
            // accepted result
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                    report_err($sformatf("unexpected result handle %h seq %h",
                                         out_handle, out_seq));
                else if (kind !== awaited[0].kind || out_handle !== awaited[0].handle
                         || out_seq !== awaited[0].seq || by_timeout !== awaited[0].to
                         || last !== awaited[0].last)
                begin
                    report_err($sformatf(
                        "got kind %0d h %h s %h to %b l %b, want %0d %h %h %b %b",
                        kind, out_handle, out_seq, by_timeout, last,
                        awaited[0].kind, awaited[0].handle, awaited[0].seq,
                        awaited[0].to, awaited[0].last));
                    void'(awaited.pop_front());
                end
                else
                    void'(awaited.pop_front());
            end
        end
    end

endmodule

// ===== dv/packet_ordering_buffer_test.sv =====
`timescale 1ns / 1ps

module packet_ordering_buffer_test;

    localparam int WATCH_LIMIT = 5000;
    localparam int SETTLE = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = pob_pkg::OP_PKT;
    logic [15:0] seq_num = '0;
    logic [15:0] pkt_handle = '0;
    logic        is_oam = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [15:0] out_handle;
    logic [15:0] out_seq;
    logic        by_timeout;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          errors;
    int          pending;

    int          send_idle_pct;
    int          stall_pct;
    int          quiet = 0;
    logic [15:0] seq_cursor;

    always #4 clk = ~clk;

    packet_ordering_buffer u_top (.*);

    packet_ordering_buffer_check u_check (.*);

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCH_LIMIT)
        begin
            $display("packet_ordering_buffer_test: done, errors");
            $finish;
        end
    end

    task automatic send_request(input logic op, input logic [15:0] s,
                                input logic [15:0] h, input logic oam);
        in_valid <= 1'b1;
        opcode <= op;
        seq_num <= s;
        pkt_handle <= h;
        is_oam <= oam;
        do @(posedge clk); while (in_stall);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold the sender until every result is back, then wait out a settle period
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] dly, input logic [31:0] idle_t,
                            input logic [5:0] lim);
        write_reg(pob_pkg::CFG_MAX_DELAY, dly);
        write_reg(pob_pkg::CFG_IDLE_LIMIT, idle_t);
        write_reg(pob_pkg::CFG_QLIMIT, lim);
    endtask

    // mostly in-order streams with holes and swaps, ticks, oam and noise
    task automatic random_burst(input int n);
        int          pick;
        logic [15:0] s;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                s = seq_cursor + 16'($urandom_range(3));
                seq_cursor = seq_cursor + 16'($urandom_range(1, 2));
                send_request(pob_pkg::OP_PKT, s, 16'($urandom), 1'b0);
            end
            else if (pick < 72)
                send_request(pob_pkg::OP_PKT, 16'($urandom), 16'($urandom), 1'b1);
            else if (pick < 94)
                send_request(pob_pkg::OP_TICK, 16'($urandom), 16'($urandom),
                             1'($urandom));
            else
                send_request(pob_pkg::OP_PKT, 16'($urandom), 16'($urandom), 1'b0);
        end
    endtask

    initial
    begin
        logic [31:0] dly_set[6]  = '{32'd0, 32'd5, 32'd2, 32'd40, 32'hFFFF_FFFF, 32'd8};
        logic [31:0] idle_set[6] = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd6, 32'd2};
        logic [5:0]  lim_set[6]  = '{6'd32, 6'd4, 6'd63, 6'd1, 6'd0, 6'd16};
        send_idle_pct = 0;
        stall_pct = 0;
        seq_cursor = 16'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: oam extremes, in and out of order, expiry, sequence extremes
        set_regs(32'd3, 32'd2, 6'd32);
        send_request(pob_pkg::OP_PKT, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(pob_pkg::OP_PKT, 16'h0000, 16'h0000, 1'b1);
        send_request(pob_pkg::OP_PKT, 16'd1, 16'h1111, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd3, 16'h3333, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd4, 16'h4444, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd2, 16'h2222, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd9, 16'h9999, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd7, 16'h7777, 1'b0);
        repeat (4) send_request(pob_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'd3, 16'hAAAA, 1'b0);
        repeat (3) send_request(pob_pkg::OP_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(pob_pkg::OP_PKT, 16'hFFFF, 16'h5555, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'h0000, 16'hAAAA, 1'b0);
        wait_quiet();
        // full buffer drops, saturated deadline
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1);
        send_request(pob_pkg::OP_PKT, 16'h8000, 16'h0101, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'h8001, 16'h0202, 1'b0);
        send_request(pob_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        send_request(pob_pkg::OP_PKT, 16'h7FFF, 16'h0303, 1'b0);
        wait_quiet();
        set_regs(32'd0, 32'd0, 6'd32);
        send_request(pob_pkg::OP_TICK, 16'h0000, 16'h0000, 1'b0);
        wait_quiet();

        // random phases with varied idling
        for (int p = 0; p < 6; p++)
        begin
            set_regs(dly_set[p], idle_set[p], lim_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            if ($urandom_range(3) == 0)
                seq_cursor = 16'($urandom);
            random_burst(35);
            if (p == 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            random_burst(35);
            wait_quiet();
        end

        in_valid <= 1'b0;
        stall_pct = 0;
        wait_quiet();
        if (errors == 0)
            $display("packet_ordering_buffer_test: done, clean");
        else
            $display("packet_ordering_buffer_test: done, errors");
        $finish;
    end

endmodule
